[rtl/core/sv39m_pkg.sv]
`default_nettype none

package sv39m_pkg;

  // Sv39 field geometry
  localparam int unsigned IDX_W    = 9;                 // index bits per table level
  localparam int unsigned ENTRIES  = 1 << IDX_W;
  localparam int unsigned VPN_W    = 27;
  localparam int unsigned PPN_W    = 44;
  localparam int unsigned CNT_W    = 21;
  localparam int unsigned PERM_W   = 3;
  localparam int unsigned TIU_W    = 7;
  localparam int unsigned VPN1_LSB = 9;
  localparam int unsigned VPN2_LSB = 18;

  // Stored PTE: ppn in [53:10], flags in [9:0]; no upper reserved bits are stored
  localparam int unsigned PTE_PPN_LSB = 10;
  localparam int unsigned PTE_W       = PTE_PPN_LSB + PPN_W;

  // APB configuration port
  localparam int unsigned APB_DW = 64;
  localparam int unsigned APB_AW = 4;

  // Register index, taken from paddr[3] (8-byte stride)
  localparam logic REG_TABLE_BASE = 1'b0;

  typedef logic [VPN_W-1:0]  vpn_t;
  typedef logic [PPN_W-1:0]  ppn_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PERM_W-1:0] perm_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PTE_W-1:0]  pte_t;
  typedef logic [TIU_W-1:0]  tiu_t;

endpackage

`default_nettype wire

[rtl/core/sv39m_in_if.sv]
`default_nettype none

interface sv39m_in_if import sv39m_pkg::*; ();
  logic  valid;
  logic  ready;
  vpn_t  virt_page;
  ppn_t  phys_page;
  cnt_t  page_count;
  perm_t perm;

  modport source (output valid, virt_page, phys_page, page_count, perm, input ready);
  modport sink   (input valid, virt_page, phys_page, page_count, perm, output ready);
endinterface

`default_nettype wire

[rtl/core/sv39m_out_if.sv]
`default_nettype none

interface sv39m_out_if import sv39m_pkg::*; ();
  logic valid;
  logic ready;
  logic status;
  cnt_t pages_mapped;
  tiu_t tables_in_use;

  modport source (output valid, status, pages_mapped, tables_in_use, input ready);
  modport sink   (input valid, status, pages_mapped, tables_in_use, output ready);
endinterface

`default_nettype wire

[rtl/core/sv39m_ram.sv]
`default_nettype none

module sv39m_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/sv39_page_table_mapper_top.sv]
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    virt_page[27], phys_page[44], page_count[21], perm[3]
// out_ch    out  valid/ready    status[1], pages_mapped[21], tables_in_use[7]
// APB       in   psel/penable   paddr[4], pwdata[64] -> table_base_ppn at byte 0
//
// Request time is set by the single-port table store: each page does two dependent
// reads (root, then middle table) and one leaf write, and a new table is zeroed
// one entry a cycle. After reset the root table is zeroed before in_ch.ready
// rises; APB writes are taken during that pass. in_ch.ready is high only when
// idle; the result holds on out_ch until it is taken.
module sv39_page_table_mapper_top
  import sv39m_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sv39m_in_if.sink               in_ch,
  sv39m_out_if.source            out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready
);

  localparam int unsigned PAGE_W  = $clog2(TABLE_PAGES);
  localparam int unsigned ALLOC_W = $clog2(TABLE_PAGES + 1);
  localparam int unsigned DEPTH   = TABLE_PAGES * ENTRIES;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,   // zero one table page, one entry a cycle
    ST_IDLE = 7'b0000010,
    ST_RD   = 7'b0000100,   // issue read of the walk entry
    ST_CHK  = 7'b0001000,   // check entry: follow, or allocate
    ST_PTR  = 7'b0010000,   // write pointer PTE to the fresh table
    ST_LEAF = 7'b0100000,   // write leaf PTE, advance page
    ST_DONE = 7'b1000000    // hold result until transfer
  } state_t;

  typedef enum logic {
    LVL_2 = 1'b0,
    LVL_1 = 1'b1
  } level_t;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [ALLOC_W-1:0] alloc_t;

  // Control state
  state_t state_r, state_nxt;
  level_t lvl_r, lvl_nxt;
  alloc_t alloc_r, alloc_nxt;
  idx_t   clr_idx_r, clr_idx_nxt;
  page_t  clr_page_r, clr_page_nxt;
  logic   clr_ret_r, clr_ret_nxt;     // 1: return to pointer write, 0: to idle
  ppn_t   base_r, base_nxt;

  // Request payload and walk state
  vpn_t  vp_r, vp_nxt;
  ppn_t  pp_r, pp_nxt;
  cnt_t  cnt_r, cnt_nxt;
  cnt_t  done_r, done_nxt;
  perm_t perm_r, perm_nxt;
  page_t tbl_r, tbl_nxt;
  page_t new_pg_r, new_pg_nxt;
  logic  status_r, status_nxt;

  // Table store
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  pte_t              ram_wdata, ram_rdata;

  idx_t  slot;
  ppn_t  ent_ppn, ent_rel;
  logic  ent_hit;
  logic  cfg_wr;

  sv39m_ram #(
    .WIDTH (PTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // APB: one register, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[APB_AW-1] == REG_TABLE_BASE) ? APB_DW'(base_r) : '0;

  // Walk index for the current level
  assign slot = (lvl_r == LVL_2) ? vp_r[VPN2_LSB +: IDX_W] : vp_r[VPN1_LSB +: IDX_W];

  // A valid pointer counts only if it lands on an allocated store page
  assign ent_ppn = ram_rdata[PTE_PPN_LSB +: PPN_W];
  assign ent_rel = ent_ppn - base_r;
  assign ent_hit = ram_rdata[0] && (ent_rel < PPN_W'(alloc_r));

  assign ram_re    = (state_r == ST_RD);
  assign ram_raddr = ADDR_W'({tbl_r, slot});

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = (state_r == ST_DONE);
  assign out_ch.status        = status_r;
  assign out_ch.pages_mapped  = done_r;
  assign out_ch.tables_in_use = TIU_W'(alloc_r);

  always_comb begin
    state_nxt    = state_r;
    lvl_nxt      = lvl_r;
    alloc_nxt    = alloc_r;
    clr_idx_nxt  = clr_idx_r;
    clr_page_nxt = clr_page_r;
    clr_ret_nxt  = clr_ret_r;
    base_nxt     = base_r;
    vp_nxt       = vp_r;
    pp_nxt       = pp_r;
    cnt_nxt      = cnt_r;
    done_nxt     = done_r;
    perm_nxt     = perm_r;
    tbl_nxt      = tbl_r;
    new_pg_nxt   = new_pg_r;
    status_nxt   = status_r;
    ram_we       = 1'b0;
    ram_waddr    = ADDR_W'({tbl_r, slot});
    ram_wdata    = '0;

    if (cfg_wr && (paddr[APB_AW-1] == REG_TABLE_BASE)) begin
      base_nxt = pwdata[PPN_W-1:0];
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = ADDR_W'({clr_page_r, clr_idx_r});
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == idx_t'(ENTRIES - 1)) begin
          state_nxt = clr_ret_r ? ST_PTR : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          vp_nxt     = in_ch.virt_page;
          pp_nxt     = in_ch.phys_page;
          cnt_nxt    = in_ch.page_count;
          perm_nxt   = in_ch.perm;
          done_nxt   = '0;
          status_nxt = 1'b0;
          tbl_nxt    = '0;
          lvl_nxt    = LVL_2;
          state_nxt  = (in_ch.page_count == '0) ? ST_DONE : ST_RD;
        end
      end

      ST_RD: begin
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        if (ent_hit) begin
          tbl_nxt = ent_rel[PAGE_W-1:0];
          if (lvl_r == LVL_2) begin
            lvl_nxt   = LVL_1;
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_LEAF;
          end
        end else if (alloc_r >= ALLOC_W'(TABLE_PAGES)) begin
          // out of table pages: drop the rest of the request
          status_nxt = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          new_pg_nxt   = alloc_r[PAGE_W-1:0];
          clr_page_nxt = alloc_r[PAGE_W-1:0];
          clr_idx_nxt  = '0;
          clr_ret_nxt  = 1'b1;
          alloc_nxt    = alloc_r + 1'b1;
          state_nxt    = ST_CLR;
        end
      end

      ST_PTR: begin
        ram_we    = 1'b1;
        ram_wdata = {base_r + PPN_W'(new_pg_r), (PTE_PPN_LSB - 1)'(0), 1'b1};
        tbl_nxt   = new_pg_r;
        if (lvl_r == LVL_2) begin
          lvl_nxt   = LVL_1;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_LEAF;
        end
      end

      ST_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'({tbl_r, vp_r[IDX_W-1:0]});
        ram_wdata = {pp_r, (PTE_PPN_LSB - PERM_W - 1)'(0), perm_r, 1'b1};
        done_nxt  = done_r + 1'b1;
        vp_nxt    = vp_r + 1'b1;
        pp_nxt    = pp_r + 1'b1;
        tbl_nxt   = '0;
        lvl_nxt   = LVL_2;
        state_nxt = (done_r + 1'b1 == cnt_r) ? ST_DONE : ST_RD;
      end

      ST_DONE: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the root-table clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      lvl_r      <= LVL_2;
      alloc_r    <= alloc_t'(1);
      clr_idx_r  <= '0;
      clr_page_r <= '0;
      clr_ret_r  <= 1'b0;
      base_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      lvl_r      <= lvl_nxt;
      alloc_r    <= alloc_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_page_r <= clr_page_nxt;
      clr_ret_r  <= clr_ret_nxt;
      base_r     <= base_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    vp_r     <= vp_nxt;
    pp_r     <= pp_nxt;
    cnt_r    <= cnt_nxt;
    done_r   <= done_nxt;
    perm_r   <= perm_nxt;
    tbl_r    <= tbl_nxt;
    new_pg_r <= new_pg_nxt;
    status_r <= status_nxt;
  end

endmodule

`default_nettype wire

[dv/sv39_mapping_checker.sv]
module sv39_mapping_checker
  import sv39m_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sv39m_in_if                    in_mon,
  sv39m_out_if                   out_mon,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  input  wire logic              pready,
  output int unsigned            pending,
  output int unsigned            errors
);

  localparam logic [PTE_PPN_LSB-1:0] PTR_FLAGS = 1;

  typedef struct packed {
    logic status;
    cnt_t pages_mapped;
    tiu_t tables_in_use;
  } map_outcome_t;

  pte_t         pt_mem [TABLE_PAGES*ENTRIES];
  int unsigned  tables_used;
  ppn_t         base_ppn;
  map_outcome_t outcome_q [$];

  // Follow the pointer in slot of table tbl, or hand out and clear a fresh table.
  // Return -1 once the table pool is exhausted.
  function automatic int descend(int unsigned tbl, idx_t slot);
    int unsigned pos;
    int unsigned fresh;
    ppn_t        rel;
    pos = tbl * ENTRIES + slot;
    if (pt_mem[pos][0]) begin
      rel = pt_mem[pos][PTE_W-1:PTE_PPN_LSB] - base_ppn;
      if (rel < ppn_t'(tables_used)) return int'(rel);
    end
    if (tables_used >= TABLE_PAGES) return -1;
    fresh = tables_used;
    tables_used++;
    for (int i = 0; i < ENTRIES; i++) pt_mem[fresh*ENTRIES + i] = '0;
    pt_mem[pos] = {ppn_t'(base_ppn + fresh), PTR_FLAGS};
    return int'(fresh);
  endfunction

  function automatic map_outcome_t predict_mapping(vpn_t vp, ppn_t pp, cnt_t cnt, perm_t pm);
    map_outcome_t res;
    int           mid;
    int           leaf;
    int unsigned  done;
    res.status = 1'b0;
    done = 0;
    while (done < cnt) begin
      mid = descend(0, vp[VPN2_LSB +: IDX_W]);
      if (mid < 0) begin
        res.status = 1'b1;
        break;
      end
      leaf = descend(unsigned'(mid), vp[VPN1_LSB +: IDX_W]);
      if (leaf < 0) begin
        res.status = 1'b1;
        break;
      end
      pt_mem[unsigned'(leaf)*ENTRIES + vp[IDX_W-1:0]] = {pp, 6'b000000, pm, 1'b1};
      done++;
      vp++;
      pp++;
    end
    res.pages_mapped  = cnt_t'(done);
    res.tables_in_use = tiu_t'(tables_used);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    map_outcome_t want;
    map_outcome_t got;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_PAGES*ENTRIES; i++) pt_mem[i] = '0;
      tables_used = 1;
      base_ppn    = '0;
      errors      = 0;
      outcome_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[3] == REG_TABLE_BASE)
        base_ppn = pwdata[PPN_W-1:0];
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.status, out_mon.pages_mapped, out_mon.tables_in_use};
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d pages=%0d tables=%0d", $time,
                   got.status, got.pages_mapped, got.tables_in_use);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected status=%0d pages=%0d tables=%0d, got status=%0d pages=%0d tables=%0d",
                     $time, want.status, want.pages_mapped, want.tables_in_use,
                     got.status, got.pages_mapped, got.tables_in_use);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        outcome_q.push_back(predict_mapping(in_mon.virt_page, in_mon.phys_page,
                                            in_mon.page_count, in_mon.perm));
    end
    pending = outcome_q.size();
  end

endmodule

[dv/sv39_page_table_mapper_top_test.sv]
module sv39_page_table_mapper_top_test;
  import sv39m_pkg::*;

  localparam int unsigned TABLE_PAGES = 64;
  // Worst silent stretch: one request that fills every table page.
  localparam int unsigned IDLE_LIMIT = 1_000_000;
  localparam logic [APB_AW-1:0] TABLE_BASE_ADDR = {REG_TABLE_BASE, 3'b000};
  localparam ppn_t PPN_ALL_ONES = '1;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  int unsigned       pending;
  int unsigned       errors;
  int unsigned       idle_cycles;
  int unsigned       stall_left;
  bit                calm;

  sv39m_in_if  in_ch ();
  sv39m_out_if out_ch ();

  sv39_page_table_mapper_top #(.TABLE_PAGES(TABLE_PAGES)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Passive side: watch both channels and the APB bus, predict, compare.
  sv39_mapping_checker #(.TABLE_PAGES(TABLE_PAGES)) mapping_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .pending (pending),
    .errors  (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one; none at all
  // while the calm window is open.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  // Offer one mapping request and hold it until the transfer happens.
  // Enter and leave on a falling edge; valid stays high across back-to-back items.
  task automatic send_request(vpn_t vp, ppn_t pp, cnt_t cnt, perm_t pm);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.virt_page  <= vp;
    in_ch.phys_page  <= pp;
    in_ch.page_count <= cnt;
    in_ch.perm       <= pm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random request. Most land in a small pool of root and middle slots so the
  // tables get reused and pages really get mapped; a few stray anywhere and
  // burn table pages, which drives the allocator toward exhaustion.
  task automatic send_random_request(bit allow_huge);
    vpn_t        vp;
    idx_t        top_idx;
    idx_t        mid_idx;
    cnt_t        cnt;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      vp = vpn_t'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       top_idx = '0;
        1:       top_idx = idx_t'(1);
        default: top_idx = '1;
      endcase
      if ($urandom_range(0, 7) == 7) mid_idx = '1;
      else mid_idx = idx_t'($urandom_range(0, 6));
      vp = {top_idx, mid_idx, idx_t'($urandom)};
    end
    r = $urandom_range(0, 99);
    if (r < 3) cnt = '0;
    else if (r < 75) cnt = cnt_t'($urandom_range(1, 8));
    else if (r < 95) cnt = cnt_t'($urandom_range(9, 64));
    else if (r < 99 || !allow_huge) cnt = cnt_t'($urandom_range(65, 2047));
    else cnt = cnt_t'($urandom_range(2048, 1 << 20));
    send_request(vp, {12'($urandom), 32'($urandom)}, cnt, perm_t'($urandom));
  endtask

  // Drop valid so the last request is not offered again, drain every
  // outstanding result, let the block settle, then write the table base
  // through a setup and an access phase. Junk goes in the unused upper data bits.
  task automatic reprogram_table_base(ppn_t base);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TABLE_BASE_ADDR;
    pwdata  <= {20'($urandom), base};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: drop ready for random stretches, with calm windows of none.
  initial begin
    out_ch.ready = 1'b0;
    calm         = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either channel for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.virt_page  = '0;
    in_ch.phys_page  = '0;
    in_ch.page_count = '0;
    in_ch.perm       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Base at zero; the block is still clearing its root table, which the
    // port tolerates.
    reprogram_table_base('0);

    // Directed: zero count with every field at its top value.
    send_request('1, PPN_ALL_ONES, '0, '1);
    // Single page at the very bottom of both spaces.
    send_request('0, '0, cnt_t'(1), '0);
    // Every permission combination on neighboring pages of one leaf table.
    for (int p = 0; p < 8; p++)
      send_request(vpn_t'(9'h100 + p), ppn_t'(p), cnt_t'(1), perm_t'(p));
    // Both page numbers wrap past their top into zero mid-request.
    send_request('1 - vpn_t'(1), PPN_ALL_ONES - ppn_t'(1), cnt_t'(4), '1);
    // Step off the end of a leaf table into a new one.
    send_request(vpn_t'(9'h1ff), ppn_t'(44'h123_4567_89ab), cnt_t'(2), perm_t'(3));
    // Step off the end of a middle table into the next root slot.
    send_request({9'd0, 9'h1ff, 9'h1ff}, ppn_t'(44'hfed_cba9_8765), cnt_t'(2), perm_t'(5));
    // A run long enough to span several leaf tables under a fresh root slot.
    send_request({9'd2, 9'd0, 9'd500}, ppn_t'(44'h800_0000_0000), cnt_t'(1100), perm_t'(6));
    // Alternating bit patterns in the page numbers.
    send_request(vpn_t'(27'h5555555), ppn_t'(44'h555_5555_5555), cnt_t'(1), perm_t'(5));
    send_request(vpn_t'(27'h2aaaaaa), ppn_t'(44'haaa_aaaa_aaaa), cnt_t'(1), perm_t'(2));

    // Bulk traffic at base zero; strays exhaust the table pool along the way.
    repeat (700) send_random_request(1'b0);

    // Base at its top: every stored pointer now resolves one table further on,
    // and the last table's pointer falls outside the store.
    reprogram_table_base(PPN_ALL_ONES);
    repeat (400) send_random_request(1'b0);

    // Arbitrary base: pointers land outside the store and walks fail.
    reprogram_table_base({12'($urandom), 32'($urandom)});
    repeat (200) send_random_request(1'b0);

    // Back to zero: the original tables resolve again. Allow a few huge counts,
    // which run until they leave the existing tables.
    reprogram_table_base('0);
    repeat (700) send_random_request(1'b1);
    send_request('0, {12'($urandom), 32'($urandom)}, cnt_t'(1 << 20), '1);

    // Drain, give the block time to go idle, then rule.
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
